[src/msb_pkg.sv]
// Shared constants, types and helpers for the multi-stack shared buffer.
`default_nettype none
package msb_pkg;

  localparam int NUM_STACKS = 4;
  localparam int NUM_SLOTS  = 16;

  // A pointer holds a slot index or the null code NUM_SLOTS.
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int SID_W  = 2;
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int STK_CALC_W = (STK_W > SID_W) ? STK_W : SID_W;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [STK_W-1:0]  stk_t;
  typedef logic [1:0]        status_t;

  localparam ptr_t PTR_NULL = ptr_t'(NUM_SLOTS);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_WORD = 32'sh7FFF_FFFF;

  // Reduce a stack id modulo NUM_STACKS; the id is below four, so three
  // compare-and-subtract steps always suffice.
  function automatic stk_t stk_index(input logic [SID_W-1:0] sid);
    logic [STK_CALC_W-1:0] v;
    v = STK_CALC_W'(sid);
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= NUM_STACKS) begin
        v = v - STK_CALC_W'(NUM_STACKS);
      end
    end
    return v[STK_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/msb_if.sv]
// Request and result channel interfaces of the multi-stack shared buffer.
`default_nettype none
interface msb_in_if import msb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [SID_W-1:0]   stack_id;
  logic signed [31:0] push_value;

  modport source (output valid, output operation, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input operation, input stack_id, input push_value,
                  output ready);
endinterface

interface msb_out_if import msb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  status_t            status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface
`default_nettype wire

[src/multi_stack_shared_buffer.sv]
// Several stacks in one shared slot memory, managed by a linked free list.
// A refused push or pop answers in the cycle after acceptance; an accepted
// one first reads the link and data memories into registers, then answers;
// no new request is taken while one is in flight or the output is held.
// Reset: all stacks empty, free list in slot order; ready right after reset,
// untouched slots are tracked by a fill count, so no clearing pass runs.
`default_nettype none
module multi_stack_shared_buffer import msb_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  msb_in_if.sink       in_chan,
  msb_out_if.source    out_chan
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic               state_r;
  ptr_t               free_head_r;
  ptr_t               heads_r [NUM_STACKS];
  ptr_t               fill_r;

  logic               op_r;
  stk_t               stk_r;
  slot_t              slot_r;
  ptr_t               head_r;
  logic signed [31:0] val_r;
  logic               fresh_r;

  ptr_t               link_mem [NUM_SLOTS];
  logic signed [31:0] data_mem [NUM_SLOTS];
  ptr_t               link_rd_r;
  logic signed [31:0] data_rd_r;

  logic               out_valid_r;
  logic signed [31:0] out_pop_value_r;
  status_t            out_status_r;

  logic  out_free;
  logic  accept;
  logic  issue;
  logic  finish;
  stk_t  stk;
  ptr_t  cur_head;
  ptr_t  slot_ptr;
  logic  slot_ok;
  ptr_t  link_val;
  ptr_t  link_wdata;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign accept        = in_chan.valid && in_chan.ready;

  assign stk      = stk_index(in_chan.stack_id);
  assign cur_head = heads_r[stk];
  assign slot_ptr = (in_chan.operation == OP_PUSH) ? free_head_r : cur_head;
  assign slot_ok  = slot_ptr < PTR_NULL;
  assign issue    = accept && slot_ok;
  assign finish   = (state_r == S_WAIT) && out_free;

  // A slot never handed out yet still links to its successor.
  always_comb begin
    if (fresh_r) begin
      if (slot_r == slot_t'(NUM_SLOTS - 1)) begin
        link_val = PTR_NULL;
      end else begin
        link_val = ptr_t'(slot_r) + ptr_t'(1);
      end
    end else begin
      link_val = link_rd_r;
    end
  end

  assign link_wdata = (op_r == OP_PUSH) ? head_r : free_head_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      link_rd_r <= link_mem[slot_ptr[SLOT_W-1:0]];
      data_rd_r <= data_mem[slot_ptr[SLOT_W-1:0]];
    end
    if (finish) begin
      link_mem[slot_r] <= link_wdata;
    end
    if (finish && op_r == OP_PUSH) begin
      data_mem[slot_r] <= val_r;
    end
  end

  // Hold the request while the memory read is in flight.
  always_ff @(posedge clk) begin
    if (issue) begin
      op_r    <= in_chan.operation;
      stk_r   <= stk;
      slot_r  <= slot_ptr[SLOT_W-1:0];
      head_r  <= cur_head;
      val_r   <= in_chan.push_value;
      fresh_r <= slot_ptr >= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !slot_ok) begin
      if (in_chan.operation == OP_PUSH) begin
        out_pop_value_r <= '0;
        out_status_r    <= ST_FULL;
      end else begin
        out_pop_value_r <= EMPTY_WORD;
        out_status_r    <= ST_EMPTY;
      end
    end else if (finish) begin
      out_pop_value_r <= (op_r == OP_PUSH) ? 32'sd0 : data_rd_r;
      out_status_r    <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_r[i] <= PTR_NULL;
      end
    end else begin
      if (issue) begin
        state_r <= S_WAIT;
      end else if (finish) begin
        state_r <= S_IDLE;
      end

      if (finish) begin
        if (op_r == OP_PUSH) begin
          free_head_r    <= link_val;
          heads_r[stk_r] <= ptr_t'(slot_r);
          if (fresh_r) begin
            fill_r <= fill_r + ptr_t'(1);
          end
        end else begin
          heads_r[stk_r] <= link_val;
          free_head_r    <= ptr_t'(slot_r);
        end
      end

      if ((accept && !slot_ok) || finish) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pop_value = out_pop_value_r;
  assign out_chan.status    = out_status_r;

endmodule
`default_nettype wire
